### hdl/stack_machine_executor_macros.svh
// ----------------------------------------------------------------------------
// Stack machine executor assertion macros
// Shared property shapes for the port checker.
// ----------------------------------------------------------------------------
`ifndef STACK_MACHINE_EXECUTOR_MACROS_SVH
`define STACK_MACHINE_EXECUTOR_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SME_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define SME_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/sme_pkg.sv
// ----------------------------------------------------------------------------
// Stack machine executor package
// Sizes, opcodes, state codes and payload types shared by the block.
// ----------------------------------------------------------------------------
package sme_pkg;

    localparam int DATA_W      = 64;
    localparam int PC_W        = 16;
    localparam int STACK_DEPTH = 64;
    localparam int VAR_COUNT   = 256;
    localparam int STK_AW      = $clog2(STACK_DEPTH);
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int VAR_AW      = $clog2(VAR_COUNT);
    localparam int CNT_W       = $clog2(DATA_W);

    typedef enum logic [4:0] {
        OP_PUSH  = 5'd0,
        OP_LOAD  = 5'd1,
        OP_STORE = 5'd2,
        OP_ADD   = 5'd3,
        OP_SUB   = 5'd4,
        OP_MUL   = 5'd5,
        OP_DIV   = 5'd6,
        OP_MOD   = 5'd7,
        OP_NEG   = 5'd8,
        OP_LT    = 5'd9,
        OP_LE    = 5'd10,
        OP_GT    = 5'd11,
        OP_GE    = 5'd12,
        OP_EQ    = 5'd13,
        OP_NE    = 5'd14,
        OP_JMP   = 5'd15,
        OP_JMPF  = 5'd16,
        OP_PRINT = 5'd17,
        OP_HALT  = 5'd18
    } op_t;

    typedef enum logic [1:0] {
        ERR_NONE = 2'd0,
        ERR_DIV0 = 2'd1,
        ERR_MOD0 = 2'd2,
        ERR_OVF  = 2'd3
    } err_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD1,
        S_RD2,
        S_EXEC,
        S_ITER,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        MD_MUL,
        MD_DIV,
        MD_MOD
    } md_op_t;

    typedef struct packed {
        logic [4:0]         mode;
        logic signed [63:0] operand;
        logic [7:0]         var_index;
        logic               row_hit;
        logic signed [63:0] row_value;
        logic               start_program;
    } in_t;

    typedef struct packed {
        logic [15:0]        next_pc;
        logic               print_valid;
        logic signed [63:0] print_value;
        logic               halted;
        logic signed [63:0] result_value;
        logic [1:0]         error_code;
    } out_t;

    typedef struct packed {
        logic              start;
        md_op_t            op;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
    } md_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] result;
    } md_rsp_t;

endpackage

### hdl/sme_muldiv.sv
// ----------------------------------------------------------------------------
// Stack machine executor multiply and divide unit
// One shared 65-bit adder, one bit per cycle: shift-add multiply, restoring
// divide on magnitudes, then a sign fix-up step through the same adder.
// ----------------------------------------------------------------------------
module sme_muldiv (
    input  logic             clk,
    input  logic             rst_n,
    input  sme_pkg::md_req_t req,
    output sme_pkg::md_rsp_t rsp
);

    logic                             busy_reg, busy_next;
    logic                             fix_reg, fix_next;
    logic                             done_reg, done_next;
    logic [sme_pkg::CNT_W-1:0]        cnt_reg, cnt_next;
    sme_pkg::md_op_t                  op_reg, op_next;
    logic                             neg_reg, neg_next;
    logic [sme_pkg::DATA_W-1:0]       acc_reg, acc_next;
    logic [sme_pkg::DATA_W-1:0]       x_reg, x_next;
    logic [sme_pkg::DATA_W-1:0]       y_reg, y_next;
    logic [sme_pkg::DATA_W-1:0]       res_reg, res_next;

    logic [sme_pkg::DATA_W-1:0]       mag_a, mag_b, rem_sh;
    logic [sme_pkg::DATA_W-1:0]       add_x, add_y;
    logic                             add_sub;
    logic [sme_pkg::DATA_W:0]         add_sum;

    // Magnitudes of the operands for a new divide
    assign mag_a = req.a[sme_pkg::DATA_W-1] ? (~req.a + 1'b1) : req.a;
    assign mag_b = req.b[sme_pkg::DATA_W-1] ? (~req.b + 1'b1) : req.b;
    assign rem_sh = {acc_reg[sme_pkg::DATA_W-2:0], x_reg[sme_pkg::DATA_W-1]};

    // Select the shared adder operands
    always_comb
    begin
        if (fix_reg)
        begin
            add_x   = '0;
            add_y   = (op_reg == sme_pkg::MD_DIV) ? x_reg : acc_reg;
            add_sub = neg_reg;
        end
        else if (op_reg == sme_pkg::MD_MUL)
        begin
            add_x   = acc_reg;
            add_y   = x_reg;
            add_sub = 1'b0;
        end
        else
        begin
            add_x   = rem_sh;
            add_y   = y_reg;
            add_sub = 1'b1;
        end
        add_sum = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)}
                + {{sme_pkg::DATA_W{1'b0}}, add_sub};
    end

    // Advance one bit per cycle
    always_comb
    begin
        busy_next = busy_reg;
        fix_next  = fix_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        neg_next  = neg_reg;
        acc_next  = acc_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        res_next  = res_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            fix_next  = 1'b0;
            cnt_next  = '0;
            op_next   = req.op;
            acc_next  = '0;
            if (req.op == sme_pkg::MD_MUL)
            begin
                x_next   = req.a;
                y_next   = req.b;
                neg_next = 1'b0;
            end
            else
            begin
                x_next   = mag_a;
                y_next   = mag_b;
                neg_next = (req.op == sme_pkg::MD_DIV)
                         ? (req.a[sme_pkg::DATA_W-1] ^ req.b[sme_pkg::DATA_W-1])
                         : req.a[sme_pkg::DATA_W-1];
            end
        end
        else if (busy_reg && !fix_reg)
        begin
            if (op_reg == sme_pkg::MD_MUL)
            begin
                if (y_reg[0])
                begin
                    acc_next = add_sum[sme_pkg::DATA_W-1:0];
                end
                x_next = {x_reg[sme_pkg::DATA_W-2:0], 1'b0};
                y_next = {1'b0, y_reg[sme_pkg::DATA_W-1:1]};
            end
            else
            begin
                acc_next = add_sum[sme_pkg::DATA_W] ? add_sum[sme_pkg::DATA_W-1:0] : rem_sh;
                x_next   = {x_reg[sme_pkg::DATA_W-2:0], add_sum[sme_pkg::DATA_W]};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == sme_pkg::CNT_W'(sme_pkg::DATA_W - 1))
            begin
                fix_next = 1'b1;
            end
        end
        else if (fix_reg)
        begin
            res_next  = add_sum[sme_pkg::DATA_W-1:0];
            done_next = 1'b1;
            busy_next = 1'b0;
            fix_next  = 1'b0;
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fix_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= sme_pkg::MD_MUL;
            neg_reg  <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            fix_reg  <= fix_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            op_reg   <= op_next;
            neg_reg  <= neg_next;
        end
    end

    // Hold datapath
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        res_reg <= res_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = res_reg;

endmodule

### hdl/stack_machine_executor.sv
// ----------------------------------------------------------------------------
// Stack machine executor
// Runs one bytecode instruction per item against an operand stack memory,
// a variable store memory and a program counter.
//
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_ready   sme_pkg::in_t  (one instruction)
// out       output     out_valid / out_ready sme_pkg::out_t (one result)
//
// Most instructions pass through accept, two registered stack reads, one
// execute step with any stack write and one output step.
// Mul, div and mod add a pass through the bit-serial unit (64 steps, a sign
// fix-up and the done flag). One instruction is in flight at a time;
// in_ready is high only when idle. A finished result waits in the output
// register while the next item is taken; that item then waits in the output
// state until the register frees.
// Reset clears stack pointer, pc and variable valid bits at once.
// ----------------------------------------------------------------------------
module stack_machine_executor (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  sme_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output sme_pkg::out_t out_data
);

    sme_pkg::state_t               state_reg, state_next;
    sme_pkg::in_t                  it_reg;
    logic [sme_pkg::SP_W-1:0]      sp_reg, sp_next;
    logic [sme_pkg::PC_W-1:0]      pc_reg, pc_next;
    logic [sme_pkg::DATA_W-1:0]    b_reg, b_next;
    logic [sme_pkg::DATA_W-1:0]    load_reg, load_next;
    logic                          rd1_hit_reg, rd1_hit_next;
    logic                          rd2_hit_reg, rd2_hit_next;
    sme_pkg::out_t                 res_reg, res_next;
    sme_pkg::out_t                 out_reg, out_next;
    logic                          out_valid_reg, out_valid_next;
    logic [sme_pkg::VAR_COUNT-1:0] var_valid_reg, var_valid_next;

    // Stack memory
    logic [sme_pkg::DATA_W-1:0]    stk_mem [sme_pkg::STACK_DEPTH];
    logic [sme_pkg::DATA_W-1:0]    stk_rdata_reg;
    logic                          stk_re, stk_we;
    logic [sme_pkg::STK_AW-1:0]    stk_raddr, stk_waddr;
    logic [sme_pkg::DATA_W-1:0]    stk_wdata;

    // Variable memory
    logic [sme_pkg::DATA_W-1:0]    var_mem [sme_pkg::VAR_COUNT];
    logic [sme_pkg::DATA_W-1:0]    var_rdata_reg;
    logic                          var_vld_reg;
    logic                          var_re, var_we;
    logic [sme_pkg::VAR_AW-1:0]    slot;

    sme_pkg::op_t                  op;
    logic                          accept;
    logic [sme_pkg::SP_W-1:0]      sp_dec;
    logic                          sp_empty, sp_full;
    logic [sme_pkg::PC_W-1:0]      pc_adv;
    logic [sme_pkg::DATA_W-1:0]    a_val;
    logic [sme_pkg::DATA_W-1:0]    alu_x, alu_y, alu_sum;
    logic                          alu_sub;
    logic                          a_lt_b, b_lt_a, a_eq_b;
    logic                          pops1, pops2, peek;
    sme_pkg::md_req_t              md_req;
    sme_pkg::md_rsp_t              md_rsp;

    assign op       = sme_pkg::op_t'(it_reg.mode);
    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == sme_pkg::S_IDLE);
    assign slot     = sme_pkg::VAR_AW'(it_reg.var_index % sme_pkg::VAR_COUNT);
    assign sp_dec   = sp_reg - 1'b1;
    assign sp_empty = (sp_reg == '0);
    assign sp_full  = (sp_reg == sme_pkg::SP_W'(sme_pkg::STACK_DEPTH));
    assign pc_adv   = pc_reg + 1'b1;
    assign a_val    = rd2_hit_reg ? stk_rdata_reg : '0;
    assign stk_raddr = sp_dec[sme_pkg::STK_AW-1:0];
    assign stk_waddr = sp_reg[sme_pkg::STK_AW-1:0];

    // Classify stack use of the held opcode
    always_comb
    begin
        pops1 = 1'b0;
        pops2 = 1'b0;
        peek  = 1'b0;
        case (op)
            sme_pkg::OP_STORE, sme_pkg::OP_NEG, sme_pkg::OP_JMPF, sme_pkg::OP_PRINT:
            begin
                pops1 = 1'b1;
            end
            sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL, sme_pkg::OP_DIV,
            sme_pkg::OP_MOD, sme_pkg::OP_LT, sme_pkg::OP_LE, sme_pkg::OP_GT,
            sme_pkg::OP_GE, sme_pkg::OP_EQ, sme_pkg::OP_NE:
            begin
                pops1 = 1'b1;
                pops2 = 1'b1;
            end
            sme_pkg::OP_HALT:
            begin
                peek = 1'b1;
            end
            default:
            begin
                pops1 = 1'b0;
            end
        endcase
    end

    // Shared adder and compares
    always_comb
    begin
        alu_x   = a_val;
        alu_y   = b_reg;
        alu_sub = (op != sme_pkg::OP_ADD);
        if (op == sme_pkg::OP_NEG)
        begin
            alu_x = '0;
        end
        alu_sum = alu_x + (alu_sub ? ~alu_y : alu_y) + {{(sme_pkg::DATA_W-1){1'b0}}, alu_sub};
    end

    assign a_lt_b = ($signed(a_val) < $signed(b_reg));
    assign b_lt_a = ($signed(b_reg) < $signed(a_val));
    assign a_eq_b = (a_val == b_reg);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        sp_next        = sp_reg;
        pc_next        = pc_reg;
        b_next         = b_reg;
        load_next      = load_reg;
        rd1_hit_next   = rd1_hit_reg;
        rd2_hit_next   = rd2_hit_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        var_valid_next = var_valid_reg;
        stk_re         = 1'b0;
        stk_we         = 1'b0;
        stk_wdata      = '0;
        var_re         = 1'b0;
        var_we         = 1'b0;
        md_req.start   = 1'b0;
        md_req.op      = sme_pkg::MD_MUL;
        md_req.a       = a_val;
        md_req.b       = b_reg;

        // Drop the output item once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            sme_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (in_data.start_program)
                    begin
                        sp_next        = '0;
                        pc_next        = '0;
                        var_valid_next = '0;
                    end
                    state_next = sme_pkg::S_RD1;
                end
            end
            sme_pkg::S_RD1:
            begin
                rd1_hit_next = 1'b0;
                rd2_hit_next = 1'b0;
                var_re       = 1'b1;
                if ((pops1 || peek) && !sp_empty)
                begin
                    stk_re       = 1'b1;
                    rd1_hit_next = 1'b1;
                    if (pops1)
                    begin
                        sp_next = sp_dec;
                    end
                end
                state_next = sme_pkg::S_RD2;
            end
            sme_pkg::S_RD2:
            begin
                b_next    = rd1_hit_reg ? stk_rdata_reg : '0;
                load_next = it_reg.row_hit ? it_reg.row_value
                          : (var_vld_reg ? var_rdata_reg : '0);
                if (pops2 && !sp_empty)
                begin
                    stk_re       = 1'b1;
                    rd2_hit_next = 1'b1;
                    sp_next      = sp_dec;
                end
                state_next = sme_pkg::S_EXEC;
            end
            sme_pkg::S_EXEC:
            begin
                res_next   = '0;
                pc_next    = pc_adv;
                state_next = sme_pkg::S_OUT;
                case (op)
                    sme_pkg::OP_PUSH, sme_pkg::OP_LOAD:
                    begin
                        if (sp_full)
                        begin
                            res_next.error_code = sme_pkg::ERR_OVF;
                            pc_next             = pc_reg;
                        end
                        else
                        begin
                            stk_we    = 1'b1;
                            stk_wdata = (op == sme_pkg::OP_PUSH) ? it_reg.operand : load_reg;
                            sp_next   = sp_reg + 1'b1;
                        end
                    end
                    sme_pkg::OP_STORE:
                    begin
                        var_we               = 1'b1;
                        var_valid_next[slot] = 1'b1;
                    end
                    sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_NEG:
                    begin
                        stk_we    = 1'b1;
                        stk_wdata = alu_sum;
                        sp_next   = sp_reg + 1'b1;
                    end
                    sme_pkg::OP_LT, sme_pkg::OP_LE, sme_pkg::OP_GT,
                    sme_pkg::OP_GE, sme_pkg::OP_EQ, sme_pkg::OP_NE:
                    begin
                        stk_we  = 1'b1;
                        sp_next = sp_reg + 1'b1;
                        case (op)
                            sme_pkg::OP_LT: stk_wdata[0] = a_lt_b;
                            sme_pkg::OP_LE: stk_wdata[0] = !b_lt_a;
                            sme_pkg::OP_GT: stk_wdata[0] = b_lt_a;
                            sme_pkg::OP_GE: stk_wdata[0] = !a_lt_b;
                            sme_pkg::OP_EQ: stk_wdata[0] = a_eq_b;
                            default:        stk_wdata[0] = !a_eq_b;
                        endcase
                    end
                    sme_pkg::OP_MUL, sme_pkg::OP_DIV, sme_pkg::OP_MOD:
                    begin
                        if (op != sme_pkg::OP_MUL && b_reg == '0)
                        begin
                            res_next.error_code = (op == sme_pkg::OP_DIV)
                                                ? sme_pkg::ERR_DIV0 : sme_pkg::ERR_MOD0;
                            pc_next             = pc_reg;
                        end
                        else
                        begin
                            md_req.start = 1'b1;
                            md_req.op    = (op == sme_pkg::OP_MUL) ? sme_pkg::MD_MUL
                                         : ((op == sme_pkg::OP_DIV) ? sme_pkg::MD_DIV
                                                                    : sme_pkg::MD_MOD);
                            pc_next      = pc_reg;
                            state_next   = sme_pkg::S_ITER;
                        end
                    end
                    sme_pkg::OP_JMP:
                    begin
                        pc_next = it_reg.operand[sme_pkg::PC_W-1:0];
                    end
                    sme_pkg::OP_JMPF:
                    begin
                        if (b_reg == '0)
                        begin
                            pc_next = it_reg.operand[sme_pkg::PC_W-1:0];
                        end
                    end
                    sme_pkg::OP_PRINT:
                    begin
                        res_next.print_valid = 1'b1;
                        res_next.print_value = b_reg;
                    end
                    sme_pkg::OP_HALT:
                    begin
                        res_next.halted       = 1'b1;
                        res_next.result_value = b_reg;
                        pc_next               = pc_reg;
                    end
                    default:
                    begin
                        pc_next = pc_adv;
                    end
                endcase
                res_next.next_pc = pc_next;
            end
            sme_pkg::S_ITER:
            begin
                if (md_rsp.done)
                begin
                    stk_we           = 1'b1;
                    stk_wdata        = md_rsp.result;
                    sp_next          = sp_reg + 1'b1;
                    pc_next          = pc_adv;
                    res_next.next_pc = pc_adv;
                    state_next       = sme_pkg::S_OUT;
                end
            end
            sme_pkg::S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = sme_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = sme_pkg::S_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sme_pkg::S_IDLE;
            sp_reg        <= '0;
            pc_reg        <= '0;
            rd1_hit_reg   <= 1'b0;
            rd2_hit_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            var_valid_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            pc_reg        <= pc_next;
            rd1_hit_reg   <= rd1_hit_next;
            rd2_hit_reg   <= rd2_hit_next;
            out_valid_reg <= out_valid_next;
            var_valid_reg <= var_valid_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            it_reg <= in_data;
        end
        b_reg    <= b_next;
        load_reg <= load_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    // Stack memory ports
    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        if (stk_re)
        begin
            stk_rdata_reg <= stk_mem[stk_raddr];
        end
    end

    // Variable memory ports
    always_ff @(posedge clk)
    begin
        if (var_we)
        begin
            var_mem[slot] <= b_reg;
        end
        if (var_re)
        begin
            var_rdata_reg <= var_mem[slot];
            var_vld_reg   <= var_valid_reg[slot];
        end
    end

    sme_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .rsp   (md_rsp)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

### hdl/sme_checker.sv
// ----------------------------------------------------------------------------
// Stack machine executor port checker
// Watches the top-level ports; bound to the top level below.
// ----------------------------------------------------------------------------
`include "stack_machine_executor_macros.svh"

module sme_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_ready,
    input sme_pkg::in_t  in_data,
    input logic          out_valid,
    input logic          out_ready,
    input sme_pkg::out_t out_data
);

    // Hold a stalled result item
    `SME_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

    // Drop ready after taking an item
    `SME_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready, "ready stayed high after accept")

    // An error result carries no print and no halt
    `SME_ASSERT_NOW(a_err_excl, clk, rst_n, out_valid && (out_data.error_code != sme_pkg::ERR_NONE), !out_data.print_valid && !out_data.halted, "error mixed with print or halt")

    // Print and halt never together
    `SME_ASSERT_NOW(a_print_halt, clk, rst_n, out_valid && out_data.halted, !out_data.print_valid, "print and halt together")

endmodule

bind stack_machine_executor sme_checker u_sme_checker (.*);
